/* src/ctpt_pkg.sv */
// Shared types and constants of the contact table proximity tracker.
// Depends on nothing; the top level takes it in by a wildcard import.
package ctpt_pkg;

   localparam int TBL_DEPTH = 32;
   localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
   localparam int CNT_W     = $clog2(TBL_DEPTH + 1);

   localparam int MAC_W  = 48;
   localparam int TIME_W = 63;
   localparam int GAP_W  = 64;
   localparam int CFG_W  = 40;
   localparam int CSR_W  = 2;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_ADDED   = 2'd0;
   localparam status_type STATUS_UPDATED = 2'd1;
   localparam status_type STATUS_FULL    = 2'd2;
   localparam status_type STATUS_UPLOAD  = 2'd3;

   localparam logic OP_SIGHTING = 1'b0;
   localparam logic OP_UPLOAD   = 1'b1;

   localparam logic [CSR_W-1:0] CSR_MIN_GAP = 2'd0;
   localparam logic [CSR_W-1:0] CSR_MAX_GAP = 2'd1;
   localparam logic [CSR_W-1:0] CSR_FORGET  = 2'd2;

   localparam logic [CFG_W-1:0] MIN_GAP_RESET = 40'd2400000;
   localparam logic [CFG_W-1:0] MAX_GAP_RESET = 40'd12000000;
   localparam logic [CFG_W-1:0] FORGET_RESET  = 40'd12096000000;

   // One table entry: address, last sighting time and far mark.
   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [TIME_W-1:0] stamp;
      logic              far;
   } entry_type;

endpackage

/* src/contact_table_proximity_tracker.sv */
// Top level of the contact table proximity tracker: sequencer, table memory,
// configuration registers and result register. Depends on ctpt_pkg.

// A word is accepted when start is high and busy is low; busy then stays high
// until the word is finished. All table entries live in one synchronous memory
// of TBL_DEPTH entries with a registered read; the sequencer streams one read
// per cycle through it while it scans. A sighting gives one result word; an
// upload gives one word per near, unexpired contact in table order and then
// an end marker with rsp_last set. Each result is shown for exactly one cycle
// while rsp_valid is high and the receiver cannot stall it, so it must take
// every result word as it comes. Configuration writes are always ready and
// should only be made while busy is low.
module contact_table_proximity_tracker
   import ctpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Input channel
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [MAC_W-1:0]    req_mac_id,
   input  logic [TIME_W-1:0]   req_time_us,
   // Result channel
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic                rsp_near,
   output logic                rsp_has_entry,
   output logic [MAC_W-1:0]    rsp_contact_mac,
   output logic                rsp_last,
   // Configuration channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]    csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_GAP,
      S_DECIDE
   } state_type;

   // Control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0]   min_gap_ff, min_gap_in;
   logic [CFG_W-1:0]   max_gap_ff, max_gap_in;
   logic [CFG_W-1:0]   forget_ff, forget_in;

   // Payload of the word in flight and of the result register
   logic               op_ff, op_in;
   logic [MAC_W-1:0]   mac_ff, mac_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [ADDR_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [ADDR_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [TIME_W-1:0]  hit_time_ff, hit_time_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_near_ff, rsp_near_in;
   logic               rsp_has_entry_ff, rsp_has_entry_in;
   logic [MAC_W-1:0]   rsp_mac_ff, rsp_mac_in;
   logic               rsp_last_ff, rsp_last_in;

   // Table memory
   entry_type          mem_ram [TBL_DEPTH];
   entry_type          mem_q_ff;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   entry_type          wr_data;

   logic               issue;
   logic               near_hit;
   logic               fresh;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_near        = rsp_near_ff;
   assign rsp_has_entry   = rsp_has_entry_ff;
   assign rsp_contact_mac = rsp_mac_ff;
   assign rsp_last        = rsp_last_ff;

   // One read is launched per scan cycle while entries remain; its data
   // comes back from the memory in the next cycle, tagged by pend_ff.
   assign issue       = (state_ff == S_SCAN) && (rd_idx_ff < cnt_ff);
   assign mem_rd_addr = rd_idx_ff[ADDR_W-1:0];

   // An entry is uploaded when it is near and its age has not passed the
   // forget window. Stored times are below 2^63, so the 64-bit sum is exact.
   assign fresh = ({1'b0, now_ff} <=
                   ({1'b0, mem_q_ff.stamp} + {{(GAP_W-CFG_W){1'b0}}, forget_ff}));

   // Both gap bounds are exclusive; a backwards time wraps to a huge gap.
   assign near_hit = (gap_ff > {{(GAP_W-CFG_W){1'b0}}, min_gap_ff}) &&
                     (gap_ff < {{(GAP_W-CFG_W){1'b0}}, max_gap_ff});

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      rd_idx_in        = rd_idx_ff;
      pend_in          = issue;
      pend_idx_in      = rd_idx_ff[ADDR_W-1:0];
      op_in            = op_ff;
      mac_in           = mac_ff;
      now_in           = now_ff;
      hit_idx_in       = hit_idx_ff;
      hit_time_in      = hit_time_ff;
      gap_in           = gap_ff;
      min_gap_in       = min_gap_ff;
      max_gap_in       = max_gap_ff;
      forget_in        = forget_ff;
      rsp_valid_in     = 1'b0;
      rsp_status_in    = STATUS_ADDED;
      rsp_near_in      = 1'b0;
      rsp_has_entry_in = 1'b0;
      rsp_mac_in       = '0;
      rsp_last_in      = 1'b0;
      wr_en            = 1'b0;
      wr_addr          = hit_idx_ff;
      wr_data          = '{mac: mac_ff, stamp: now_ff, far: 1'b1};

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_GAP: min_gap_in = csr_wdata;
            CSR_MAX_GAP: max_gap_in = csr_wdata;
            CSR_FORGET:  forget_in  = csr_wdata;
            default: ;
         endcase
      end

      if (issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            pend_in = 1'b0;
            if (start) begin
               op_in     = req_operation;
               mac_in    = req_mac_id;
               now_in    = req_time_us;
               rd_idx_in = '0;
               state_in  = S_SCAN;
            end
         end

         S_SCAN: begin
            if (pend_ff) begin
               if (op_ff == OP_UPLOAD) begin
                  if (!mem_q_ff.far && fresh) begin
                     rsp_valid_in     = 1'b1;
                     rsp_status_in    = STATUS_UPLOAD;
                     rsp_near_in      = 1'b1;
                     rsp_has_entry_in = 1'b1;
                     rsp_mac_in       = mem_q_ff.mac;
                  end
               end else if (mem_q_ff.mac == mac_ff) begin
                  // Known address: stop the scan and work out the gap.
                  hit_idx_in  = pend_idx_ff;
                  hit_time_in = mem_q_ff.stamp;
                  pend_in     = 1'b0;
                  state_in    = S_GAP;
               end
            end else if (!issue) begin
               // Every stored entry has been looked at.
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               if (op_ff == OP_UPLOAD) begin
                  rsp_status_in = STATUS_UPLOAD;
               end else if (cnt_ff == CNT_W'(TBL_DEPTH)) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  rsp_status_in = STATUS_ADDED;
                  wr_en         = 1'b1;
                  wr_addr       = cnt_ff[ADDR_W-1:0];
                  cnt_in        = cnt_ff + 1'b1;
               end
            end
         end

         S_GAP: begin
            pend_in  = 1'b0;
            gap_in   = {1'b0, now_ff} - {1'b0, hit_time_ff};
            state_in = S_DECIDE;
         end

         S_DECIDE: begin
            pend_in       = 1'b0;
            wr_en         = 1'b1;
            wr_addr       = hit_idx_ff;
            wr_data.far   = !near_hit;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_UPDATED;
            rsp_near_in   = near_hit;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            pend_in  = 1'b0;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      mac_ff           <= mac_in;
      now_ff           <= now_in;
      pend_idx_ff      <= pend_idx_in;
      hit_idx_ff       <= hit_idx_in;
      hit_time_ff      <= hit_time_in;
      gap_ff           <= gap_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_near_ff      <= rsp_near_in;
      rsp_has_entry_ff <= rsp_has_entry_in;
      rsp_mac_ff       <= rsp_mac_in;
      rsp_last_ff      <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_gap_ff   <= MIN_GAP_RESET;
         max_gap_ff   <= MAX_GAP_RESET;
         forget_ff    <= FORGET_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         min_gap_ff   <= min_gap_in;
         max_gap_ff   <= max_gap_in;
         forget_ff    <= forget_in;
      end
   end

   // Table memory. Writes happen only on the last cycle of a word, and the
   // next word cannot launch a read before the following cycle, so a read
   // never races a write to the same entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem_ram[mem_rd_addr];
   end

`ifndef SYNTHESIS
   // The final result of a word is shown only after the sequencer is idle.
   a_last_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("final result shown while the sequencer is busy");

   // Upload entries come out only while the scan is still running.
   a_entry_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final result shown after the word finished");

   // The table never holds more entries than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TBL_DEPTH))
      else $error("entry count above table depth");

   // Writes go to a stored entry or append right after the last one.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({{(CNT_W-ADDR_W){1'b0}}, wr_addr} <= cnt_ff))
      else $error("table write beyond the fill level");

   // After a word finishes, the entry count grew by at most one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> ((cnt_ff == $past(cnt_ff)) ||
                       (cnt_ff == $past(cnt_ff) + 1'b1)))
      else $error("entry count moved by more than one");
`endif

endmodule
